FILE: rtl/larb_pkg.sv
`default_nettype none
package larb_pkg;

    localparam int NUM_SLOTS    = 8;
    localparam int TICKET_BITS  = 16;
    localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
    localparam int TOTAL_BITS   = TICKET_BITS + SLOT_BITS;
    localparam int RND_BITS     = 31;
    localparam int DIV_CNT_BITS = $clog2(RND_BITS);

    localparam int KIND_W         = 2;
    localparam int SLOT_INDEX_W   = 3;
    localparam int TICKET_COUNT_W = 16;
    localparam int READY_MASK_W   = 8;
    localparam int RANDOM_VALUE_W = 31;
    localparam int WINNER_SLOT_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET     = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DRAW    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/larb_req_if.sv
`default_nettype none
interface larb_req_if;
    import larb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [SLOT_INDEX_W-1:0]   slot_index;
    logic [TICKET_COUNT_W-1:0] ticket_count;
    logic [READY_MASK_W-1:0]   ready_mask;
    logic [RANDOM_VALUE_W-1:0] random_value;

    modport source (output valid, kind, slot_index, ticket_count, ready_mask, random_value,
                    input ready);
    modport sink   (input valid, kind, slot_index, ticket_count, ready_mask, random_value,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/larb_rsp_if.sv
`default_nettype none
interface larb_rsp_if;
    import larb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [WINNER_SLOT_W-1:0] winner_slot;
    logic                     winner_valid;

    modport source (output valid, winner_slot, winner_valid, input ready);
    modport sink   (input valid, winner_slot, winner_valid, output ready);
endinterface
`default_nettype wire

FILE: rtl/lottery_arbiter.sv
// Set and release transactions write the ticket table and give no result.
// A draw sums the tickets of the ready slots, runs a restoring division by one
// shared subtractor, scans the slots for the winner and loads the output register.
// With no ready tickets it skips the division and scan. It also waits while the previous
// result still waits in the output register; no new transaction meanwhile.
// rst_n (asynchronous, active low) clears the ticket table, sequencer and output.
`default_nettype none
module lottery_arbiter (
    input  wire        clk,
    input  wire        rst_n,
    larb_req_if.sink   req,
    larb_rsp_if.source rsp
);
    import larb_pkg::*;

    state_t state_reg, state_next;

    logic [TICKET_BITS-1:0]  table_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    mask_reg, mask_next;
    logic [RND_BITS-1:0]     rnd_reg, rnd_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic [TOTAL_BITS-1:0]   rem_reg, rem_next;
    logic [TOTAL_BITS-1:0]   running_reg, running_next;
    logic [SLOT_BITS-1:0]    idx_reg, idx_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SLOT_BITS-1:0]    win_slot_reg, win_slot_next;
    logic                    win_valid_reg, win_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [WINNER_SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic                    out_win_reg, out_win_next;

    logic                    tbl_we;
    logic [SLOT_BITS-1:0]    tbl_addr;
    logic [TICKET_BITS-1:0]  tbl_data;

    logic [TOTAL_BITS-1:0]   slot_tickets;
    logic [TOTAL_BITS-1:0]   acc_sum;
    logic [TOTAL_BITS:0]     rem_shift;
    logic                    last_slot;
    logic                    accept;

    assign req.ready        = (state_reg == ST_IDLE);
    assign accept           = req.valid && req.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.winner_slot  = out_slot_reg;
    assign rsp.winner_valid = out_win_reg;

    assign slot_tickets = mask_reg[idx_reg] ? TOTAL_BITS'(table_reg[idx_reg]) : '0;
    assign acc_sum      = (state_reg == ST_SUM) ? total_reg + slot_tickets
                                                : running_reg + slot_tickets;
    assign rem_shift    = {rem_reg, rnd_reg[RND_BITS-1]};
    assign last_slot    = (idx_reg == SLOT_BITS'(NUM_SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                table_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tbl_we)
            begin
                table_reg[tbl_addr] <= tbl_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg      <= mask_next;
        rnd_reg       <= rnd_next;
        total_reg     <= total_next;
        rem_reg       <= rem_next;
        running_reg   <= running_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        win_slot_reg  <= win_slot_next;
        win_valid_reg <= win_valid_next;
        out_slot_reg  <= out_slot_next;
        out_win_reg   <= out_win_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        rnd_next       = rnd_reg;
        total_next     = total_reg;
        rem_next       = rem_reg;
        running_next   = running_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        win_slot_next  = win_slot_reg;
        win_valid_next = win_valid_reg;
        out_slot_next  = out_slot_reg;
        out_win_next   = out_win_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        tbl_we         = 1'b0;
        tbl_addr       = SLOT_BITS'(req.slot_index);
        tbl_data       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.kind)
                        KIND_SET:
                        begin
                            tbl_we   = (int'(req.slot_index) < NUM_SLOTS);
                            tbl_data = TICKET_BITS'(req.ticket_count);
                        end
                        KIND_RELEASE:
                        begin
                            tbl_we   = (int'(req.slot_index) < NUM_SLOTS);
                        end
                        KIND_DRAW:
                        begin
                            mask_next  = NUM_SLOTS'(req.ready_mask);
                            rnd_next   = RND_BITS'(req.random_value);
                            total_next = '0;
                            idx_next   = '0;
                            state_next = ST_SUM;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                total_next = acc_sum;
                idx_next   = idx_reg + 1'b1;
                if (last_slot)
                begin
                    rem_next = '0;
                    cnt_next = DIV_CNT_BITS'(RND_BITS - 1);
                    if (acc_sum == '0)
                    begin
                        win_valid_next = 1'b0;
                        win_slot_next  = '0;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, total_reg})
                begin
                    rem_next = TOTAL_BITS'(rem_shift - {1'b0, total_reg});
                end
                else
                begin
                    rem_next = TOTAL_BITS'(rem_shift);
                end
                rnd_next = {rnd_reg[RND_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    running_next = '0;
                    idx_next     = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                running_next = acc_sum;
                idx_next     = idx_reg + 1'b1;
                if (mask_reg[idx_reg] && (acc_sum > rem_reg))
                begin
                    win_valid_next = 1'b1;
                    win_slot_next  = idx_reg;
                    state_next     = ST_FINISH;
                end
                else if (last_slot)
                begin
                    win_valid_next = 1'b0;
                    win_slot_next  = '0;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = WINNER_SLOT_W'(win_slot_reg);
                    out_win_next   = win_valid_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/larb_checker.sv
`default_nettype none
module larb_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       req_valid,
    input wire       req_ready,
    input wire [1:0] req_kind,
    input wire       rsp_valid,
    input wire       rsp_ready,
    input wire [2:0] rsp_winner_slot,
    input wire       rsp_winner_valid
);
    import larb_pkg::*;

    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_kind == KIND_DRAW) |=> ##8 !req_ready)
        else $error("ready returned too early after a draw");

    a_update_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_kind == KIND_SET || req_kind == KIND_RELEASE))
        |=> req_ready)
        else $error("set or release did not complete in one cycle");

    a_no_winner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_winner_valid) |-> (rsp_winner_slot == '0))
        else $error("no-winner result carries a nonzero slot");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
        (rsp_valid && $stable(rsp_winner_slot) && $stable(rsp_winner_valid)))
        else $error("stalled result changed");

endmodule

bind lottery_arbiter larb_checker u_larb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_kind         (req.kind),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_winner_slot  (rsp.winner_slot),
    .rsp_winner_valid (rsp.winner_valid)
);
`default_nettype wire
